// ----- rtl/longest_prefix_match_lookup_defines.svh -----
// ============================================================================
// Longest prefix match lookup - assertion macros
// Shared property wrappers for the lookup checker.
// ============================================================================
`ifndef LONGEST_PREFIX_MATCH_LOOKUP_DEFINES_SVH
`define LONGEST_PREFIX_MATCH_LOOKUP_DEFINES_SVH

// Property sampled on clk, ignored while reset is asserted.
`define LPM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property that must also hold while reset is asserted.
`define LPM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/lpm_pkg.sv -----
// ============================================================================
// LPM package
// Types, sizes and codes shared by the route lookup modules.
// ============================================================================
package lpm_pkg;

    localparam int TABLE_ENTRIES   = 16;
    localparam int INTERFACE_COUNT = 4;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    localparam int ADDR_W  = 32;
    localparam int IFACE_W = 2;
    localparam int LEN_W   = 6;
    localparam int SLOT_W  = 4;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef struct packed {
        logic               op;
        logic [SLOT_W-1:0]  entry_index;
        logic               entry_enable;
        logic [ADDR_W-1:0]  route_destination;
        logic [ADDR_W-1:0]  route_netmask;
        logic [IFACE_W-1:0] route_interface;
        logic [ADDR_W-1:0]  lookup_address;
    } lpm_in_t;

    typedef struct packed {
        logic               found;
        logic [IFACE_W-1:0] out_interface;
        logic [LEN_W-1:0]   prefix_length;
    } lpm_out_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  dest;
        logic [ADDR_W-1:0]  mask;
        logic [IFACE_W-1:0] iface;
    } lpm_entry_t;

    typedef struct packed {
        logic               hit;
        logic [IFACE_W-1:0] iface;
        logic [LEN_W-1:0]   len;
    } lpm_best_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WRITE,
        ST_SCAN,
        ST_LAST
    } lpm_state_t;

    typedef struct packed {
        logic             busy;
        logic             accept;
        logic             write_en;
        logic             cmp_en;
        logic             finish_write;
        logic             finish_lookup;
        logic [IDX_W-1:0] rd_addr;
    } lpm_ctrl_t;

endpackage

// ----- rtl/lpm_table.sv -----
// ============================================================================
// LPM route table
// Route entry memory with one write port, one registered read port and
// per-slot valid flags cleared by reset.
// ============================================================================
module lpm_table
    import lpm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  lpm_entry_t       wentry,
    input  logic             wvalid,
    input  logic [IDX_W-1:0] raddr,
    output lpm_entry_t       rentry,
    output logic             rvalid
);

    lpm_entry_t                entry_mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0]  valid_reg;
    lpm_entry_t                rentry_reg;
    logic                      rvalid_reg;

    // payload storage, no reset
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            entry_mem[waddr] <= wentry;
        end
        rentry_reg <= entry_mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= wvalid;
            end
            rvalid_reg <= valid_reg[raddr];
        end
    end

    assign rentry = rentry_reg;
    assign rvalid = rvalid_reg;

endmodule

// ----- rtl/lpm_match.sv -----
// ============================================================================
// LPM match unit
// Masked compare and mask population count for one entry; folds the entry
// into the running best match.
// ============================================================================
module lpm_match
    import lpm_pkg::*;
(
    input  lpm_entry_t        entry,
    input  logic              entry_valid,
    input  logic [ADDR_W-1:0] addr,
    input  lpm_best_t         best,
    output lpm_best_t         best_next
);

    logic [1:0]       s1 [16];
    logic [2:0]       s2 [8];
    logic [3:0]       s3 [4];
    logic [4:0]       s4 [2];
    logic [LEN_W-1:0] len;
    logic             match;
    logic             take;

    // population count tree, 32 bits -> 6 bits
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            s1[i] = {1'b0, entry.mask[2*i]} + {1'b0, entry.mask[2*i+1]};
        end
        for (int i = 0; i < 8; i++)
        begin
            s2[i] = {1'b0, s1[2*i]} + {1'b0, s1[2*i+1]};
        end
        for (int i = 0; i < 4; i++)
        begin
            s3[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
        end
        for (int i = 0; i < 2; i++)
        begin
            s4[i] = {1'b0, s3[2*i]} + {1'b0, s3[2*i+1]};
        end
        len = {1'b0, s4[0]} + {1'b0, s4[1]};
    end

    assign match = entry_valid && ((entry.mask & addr) == (entry.mask & entry.dest));
    // strict compare keeps the lower index on a tie
    assign take  = match && (!best.hit || (len > best.len));

    always_comb
    begin
        if (take)
        begin
            best_next.hit   = 1'b1;
            best_next.iface = entry.iface;
            best_next.len   = len;
        end
        else
        begin
            best_next = best;
        end
    end

endmodule

// ----- rtl/lpm_ctrl.sv -----
// ============================================================================
// LPM sequencer
// Accepts items, steps the table read address across all slots for a
// lookup and issues the table write for a write item.
// ============================================================================
module lpm_ctrl
    import lpm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      op,
    output lpm_ctrl_t ctrl
);

    lpm_state_t       state_reg;
    lpm_state_t       state_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             cmp_vld_reg;
    logic             cmp_vld_next;
    logic             last_idx;

    assign last_idx = (idx_reg == IDX_W'(TABLE_ENTRIES - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            cmp_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            cmp_vld_reg <= cmp_vld_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (op)
                        OP_WRITE:  state_next = ST_WRITE;
                        OP_LOOKUP: state_next = ST_SCAN;
                        default:   state_next = ST_WRITE;
                    endcase
                end
            end
            ST_WRITE: state_next = ST_IDLE;
            ST_SCAN:
            begin
                if (last_idx)
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs and counter
    always_comb
    begin
        ctrl          = '0;
        idx_next      = '0;
        cmp_vld_next  = 1'b0;
        ctrl.rd_addr  = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                ctrl.accept = start;
            end
            ST_WRITE:
            begin
                ctrl.busy         = 1'b1;
                ctrl.write_en     = 1'b1;
                ctrl.finish_write = 1'b1;
            end
            ST_SCAN:
            begin
                ctrl.busy    = 1'b1;
                ctrl.cmp_en  = cmp_vld_reg;
                idx_next     = idx_reg + 1'b1;
                cmp_vld_next = 1'b1;
            end
            ST_LAST:
            begin
                ctrl.busy          = 1'b1;
                ctrl.cmp_en        = 1'b1;
                ctrl.finish_lookup = 1'b1;
            end
            default:
            begin
                ctrl.busy = 1'b1;
            end
        endcase
    end

endmodule

// ----- rtl/longest_prefix_match_lookup.sv -----
// ============================================================================
// Longest prefix match lookup
// IPv4 route table with 16 slots; lookups scan the slots through one shared
// masked-compare / popcount unit and keep the longest matching prefix.
// ============================================================================
// Write item: accept, ST_WRITE, then the registered done strobe.
// Lookup item: accept, ST_SCAN over all TABLE_ENTRIES slots, ST_LAST, then the
//   registered done strobe; the match unit takes one slot per cycle from the
//   single table read port. A new item is accepted only back in ST_IDLE.
// busy stays high from the accept edge until the result strobe; done is a
// one-cycle pulse. Reset clears all slot valid flags at once; no sweep.
module longest_prefix_match_lookup
    import lpm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  lpm_in_t  item,
    output logic     done,
    output lpm_out_t result
);

    lpm_ctrl_t  ctrl;
    lpm_in_t    item_reg;
    lpm_best_t  best_reg;
    lpm_best_t  best_next;
    lpm_entry_t wentry;
    lpm_entry_t rentry;
    logic       rvalid;
    logic       table_we;
    logic       done_reg;
    lpm_out_t   result_reg;

    lpm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (item.op),
        .ctrl  (ctrl)
    );

    // item register, captured on accept
    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            item_reg <= item;
        end
    end

    // out-of-range slot or interface writes are dropped
    assign table_we = ctrl.write_en
                   && (32'(item_reg.entry_index) < TABLE_ENTRIES)
                   && (32'(item_reg.route_interface) < INTERFACE_COUNT);

    assign wentry.dest  = item_reg.route_destination;
    assign wentry.mask  = item_reg.route_netmask;
    assign wentry.iface = item_reg.route_interface;

    lpm_table u_table (
        .clk    (clk),
        .rst_n  (rst_n),
        .we     (table_we),
        .waddr  (IDX_W'(item_reg.entry_index)),
        .wentry (wentry),
        .wvalid (item_reg.entry_enable),
        .raddr  (ctrl.rd_addr),
        .rentry (rentry),
        .rvalid (rvalid)
    );

    // shared compare unit; table read data is registered, arriving the cycle after the read address
    lpm_match u_match (
        .entry       (rentry),
        .entry_valid (rvalid),
        .addr        (item_reg.lookup_address),
        .best        (best_reg),
        .best_next   (best_next)
    );

    // running best match; clear on every accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg <= '0;
        end
        else if (ctrl.accept)
        begin
            best_reg <= '0;
        end
        else if (ctrl.cmp_en)
        begin
            best_reg <= best_next;
        end
    end

    // result register and strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctrl.finish_write || ctrl.finish_lookup;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.finish_lookup)
        begin
            // no-match leaves best at zero, giving an all-zero result
            result_reg.found         <= best_next.hit;
            result_reg.out_interface <= best_next.iface;
            result_reg.prefix_length <= best_next.len;
        end
        else if (ctrl.finish_write)
        begin
            result_reg <= '0;
        end
    end

    assign busy   = ctrl.busy;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ----- rtl/lpm_check.sv -----
// ============================================================================
// LPM port checker
// Port-level temporal checks for the route lookup, bound to the top level.
// ============================================================================
`include "longest_prefix_match_lookup_defines.svh"

module lpm_check
    import lpm_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input logic     busy,
    input logic     done,
    input lpm_out_t result
);

    `LPM_ASSERT(a_accept_busy, (start && !busy) |=> busy, "busy not raised after accept")
    `LPM_ASSERT(a_done_idle, done |-> !busy, "result strobe while still busy")
    `LPM_ASSERT(a_done_pulse, done |=> !done, "result strobe held over two cycles")
    `LPM_ASSERT(a_miss_zero, (done && !result.found) |-> ((result.prefix_length == '0) && (result.out_interface == '0)), "miss result not zero")
    `LPM_ASSERT_ALWAYS(a_len_range, done |-> (result.prefix_length <= LEN_W'(ADDR_W)), "prefix length above 32")

endmodule

bind longest_prefix_match_lookup lpm_check u_lpm_check (.*);
